/* sv/gbk_to_pinyin_stream_unit_assert.svh */
// assertion macros for the gbk to pinyin stream unit
`ifndef GBK_TO_PINYIN_STREAM_UNIT_ASSERT_SVH
`define GBK_TO_PINYIN_STREAM_UNIT_ASSERT_SVH

// property that holds after reset
`define G2P_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked in the next cycle
`define G2P_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) else $error(msg);

`endif

/* sv/g2p_pkg.sv */
// shared types, constants and functions of the gbk to pinyin stream unit
`default_nettype none
package g2p_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 32768;
    localparam int unsigned MAX_LETTERS_DEF = 6;
    localparam int unsigned LETTERS_W       = 48;

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    localparam logic [2:0] CFG_INITIALS = 3'd0;
    localparam logic [2:0] CFG_PAD      = 3'd1;
    localparam logic [2:0] CFG_ORIG     = 3'd2;
    localparam logic [2:0] CFG_UPFIRST  = 3'd3;
    localparam logic [2:0] CFG_UPREST   = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef struct packed {
        logic initials_only;
        logic auto_pad;
        logic with_original;
        logic upper_first;
        logic upper_rest;
    } cfg_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_lead(input logic [7:0] h);
        return h >= 8'h81 && h <= 8'hFE;
    endfunction

    function automatic logic is_pair(input logic [7:0] h, input logic [7:0] l);
        logic low_a;
        logic low_b;
        logic r;
        low_a = l >= 8'hA1 && l <= 8'hFE;
        low_b = l >= 8'h40 && l <= 8'hA0 && l != 8'h7F;
        r = 1'b0;
        if (h >= 8'hA1 && h <= 8'hA9 && low_a) r = 1'b1;
        if (h >= 8'hB0 && h <= 8'hF7 && low_a) r = 1'b1;
        if (h >= 8'h81 && h <= 8'hA0 && l >= 8'h40 && l <= 8'hFE && l != 8'h7F) r = 1'b1;
        if (h >= 8'hAA && h <= 8'hFE && low_b) r = 1'b1;
        if (h >= 8'hA8 && h <= 8'hA9 && low_b) r = 1'b1;
        if (h >= 8'hAA && h <= 8'hAF && low_a) r = 1'b1;
        if (h >= 8'hF8 && h <= 8'hFE && low_a) r = 1'b1;
        if (h >= 8'hA1 && h <= 8'hA7 && low_b) r = 1'b1;
        return r && is_lead(h);
    endfunction

endpackage
`default_nettype wire

/* sv/g2p_table.sv */
// code table memory with one synchronous read and one write port
`default_nettype none
module g2p_table #(
    parameter int unsigned TABLE_DEPTH = g2p_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [IDX_W-1:0]           wr_idx,
    input  wire logic [15:0]                wr_code,
    input  wire logic [g2p_pkg::LETTERS_W-1:0] wr_letters,
    input  wire logic [2:0]                 wr_len,
    input  wire logic [IDX_W-1:0]           rd_idx,
    output logic      [15:0]                rd_code,
    output logic      [g2p_pkg::LETTERS_W-1:0] rd_letters,
    output logic      [2:0]                 rd_len
);
    import g2p_pkg::*;

    logic [LETTERS_W+18:0] mem [TABLE_DEPTH];
    logic [LETTERS_W+18:0] rd_word;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_len, wr_letters, wr_code};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_word <= mem[rd_idx];
    end

    assign rd_code    = rd_word[15:0];
    assign rd_letters = rd_word[LETTERS_W+15:16];
    assign rd_len     = rd_word[LETTERS_W+18:LETTERS_W+16];
endmodule
`default_nettype wire

/* sv/gbk_to_pinyin_stream_unit.sv */
// gbk to pinyin stream unit: top level with control sequencer and search
// Usage:
//  s_axis carries one word per item: tuser = mode, tdata = {entry_len,
//  entry_letters, entry_code, in_byte}. m_axis returns result words with
//  tdata = {status, byte_valid, out_byte} and tlast on the final word of
//  an item. cfg_* writes the five option bits (index 0..4); the user
//  must write them only while idle, as the block does not enforce it.
//  One item is in work at a time. A load, an end of text or a held lead
//  byte is taken without leaving idle; a load or a dropped lead gives one
//  word. A plain byte or pair runs a pad step, then one step per byte word.
//  A complete pair runs a binary search of the table: each probe reads in
//  the probe state and compares the registered word in the compare state.
//  Then a pad step and the remaining words follow at one per cycle while
//  the receiver does not stall, 1 to 11 words in all. The single read port
//  of the table memory sets the search time.
//  Reset clears table count, held lead byte and text flags; the table
//  memory itself is not cleared and needs no clearing pass.
//  When the receiver stalls, the output register holds its word and the
//  sequencer waits; s_axis_tready stays low until the item is finished.
`default_nettype none
module gbk_to_pinyin_stream_unit #(
    parameter int unsigned TABLE_DEPTH = g2p_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_LETTERS = g2p_pkg::MAX_LETTERS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // in_byte[7:0], entry_code[23:8], entry_letters[71:24], entry_len[74:72]
    input  wire logic [79:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0], byte_valid[8], status[10:9]
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import g2p_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NL_W  = $clog2(MAX_LETTERS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;

    // emit sequence codes
    localparam logic [3:0] E_PAD   = 4'd0;
    localparam logic [3:0] E_H     = 4'd1;
    localparam logic [3:0] E_L     = 4'd2;
    localparam logic [3:0] E_OPEN  = 4'd3;
    localparam logic [3:0] E_LET   = 4'd4;
    localparam logic [3:0] E_CLOSE = 4'd5;
    localparam logic [3:0] E_PB1   = 4'd6;
    localparam logic [3:0] E_PB2   = 4'd7;
    localparam logic [3:0] E_DONE  = 4'd8;
    localparam logic [3:0] E_PPAD  = 4'd9;

    logic [2:0]             state_reg, state_next;
    cfg_t                   cfg_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [15:0]            last_code_reg;
    logic [7:0]             lead_reg;
    logic                   lead_valid_reg;
    logic                   prev_pin_reg, emitted_reg, last_sp_reg;
    logic [CNT_W-1:0]       lo_reg, hi_reg;
    logic [7:0]             pa_reg;
    logic [7:0]             b_reg;
    logic [3:0]             step_reg;
    logic [NL_W-1:0]        li_reg, nlet_reg;
    logic                   plain2_reg;
    logic [LETTERS_W-1:0]   let_reg;
    logic [15:0]            obuf_reg;
    logic                   ovalid_reg, olast_reg;

    logic [CNT_W-1:0]       mid;
    logic [15:0]            rd_code, key;
    logic [LETTERS_W-1:0]   rd_letters;
    logic [2:0]             rd_len;
    logic                   in_acc, out_free, wr_en;
    logic                   text_acc, end_acc, pair_now, hit;
    logic [1:0]             mode;
    logic [7:0]             in_byte;
    logic [1:0]             load_st;
    logic                   out_load, out_char, out_last;
    logic [15:0]            out_word;
    logic [7:0]             ech;
    logic                   eskip, eend;
    logic [3:0]             estep_n;
    logic [7:0]             lch;
    logic [NL_W-1:0]        nl_calc;

    assign mode    = s_axis_tuser;
    assign in_byte = s_axis_tdata[7:0];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign text_acc = in_acc && mode == MODE_TEXT;
    assign end_acc  = in_acc && mode == MODE_END;
    assign pair_now = lead_valid_reg && is_pair(lead_reg, in_byte);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key = {lead_reg, b_reg};
    assign hit = rd_code == key;
    assign wr_en = in_acc && mode == MODE_LOAD && load_st == ST_OK;

    g2p_table #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_idx    (count_reg[IDX_W-1:0]),
        .wr_code   (s_axis_tdata[23:8]),
        .wr_letters(s_axis_tdata[71:24]),
        .wr_len    (s_axis_tdata[74:72]),
        .rd_idx    (mid[IDX_W-1:0]),
        .rd_code   (rd_code),
        .rd_letters(rd_letters),
        .rd_len    (rd_len)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INITIALS: cfg_reg.initials_only <= cfg_data[0];
                CFG_PAD:      cfg_reg.auto_pad      <= cfg_data[0];
                CFG_ORIG:     cfg_reg.with_original <= cfg_data[0];
                CFG_UPFIRST:  cfg_reg.upper_first   <= cfg_data[0];
                CFG_UPREST:   cfg_reg.upper_rest    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // emit step decode: next char of the running sequence
    always_comb begin
        lch = let_reg[7:0];
        if (li_reg == '0) begin
            if (cfg_reg.upper_first) lch = upcase(let_reg[7:0]);
        end else if (cfg_reg.upper_rest) begin
            lch = upcase(let_reg[7:0]);
        end
        ech = 8'h00; eskip = 1'b0; eend = 1'b0; estep_n = E_DONE;
        unique case (step_reg)
            E_PAD: begin
                ech = CH_SPACE;
                estep_n = cfg_reg.with_original ? E_H : E_LET;
                eskip = !(cfg_reg.auto_pad && emitted_reg && !last_sp_reg);
            end
            E_H:     begin ech = lead_reg; estep_n = E_L; end
            E_L:     begin ech = b_reg;    estep_n = E_OPEN; end
            E_OPEN:  begin ech = CH_OPEN;  estep_n = E_LET; end
            E_LET: begin
                ech = lch;
                estep_n = (li_reg + 1'b1 == nlet_reg) ?
                          (cfg_reg.with_original ? E_CLOSE : E_DONE) : E_LET;
                eend = estep_n == E_DONE;
            end
            E_CLOSE: begin ech = CH_CLOSE; eend = 1'b1; end
            E_PPAD: begin
                ech = CH_SPACE;
                estep_n = E_PB1;
                eskip = !(cfg_reg.auto_pad && prev_pin_reg && !is_space(pa_reg));
            end
            E_PB1: begin
                ech = pa_reg;
                estep_n = plain2_reg ? E_PB2 : E_DONE;
                eend = !plain2_reg;
            end
            E_PB2:   begin ech = b_reg; eend = 1'b1; end
            default: begin eskip = 1'b1; eend = 1'b1; end
        endcase
    end

    // load status and next output word
    always_comb begin
        load_st = ST_OK;
        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
            load_st = ST_FULL;
        end else if (s_axis_tdata[23:8] <= last_code_reg) begin
            load_st = ST_ORDER;
        end
        out_load = 1'b0; out_char = 1'b0; out_last = 1'b0; out_word = '0;
        if (in_acc && mode == MODE_LOAD) begin
            out_load = 1'b1; out_last = 1'b1;
            out_word = {5'd0, load_st, 1'b0, 8'h00};
        end else if (end_acc && lead_valid_reg) begin
            out_load = 1'b1; out_last = 1'b1;
            out_word = {5'd0, ST_DROP, 1'b0, 8'h00};
        end else if (state_reg == S_EMIT && out_free && !eskip) begin
            out_load = 1'b1; out_char = 1'b1; out_last = eend;
            out_word = {5'd0, ST_OK, 1'b1, ech};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        nl_calc = cfg_reg.initials_only ? NL_W'(1) :
                  (rd_len == 3'd0) ? NL_W'(1) :
                  (32'(rd_len) > MAX_LETTERS) ? NL_W'(MAX_LETTERS) : NL_W'(rd_len);
        unique case (state_reg)
            S_IDLE: if (text_acc) begin
                if (pair_now) state_next = S_PROBE;
                else if (lead_valid_reg || !is_lead(in_byte)) state_next = S_EMIT;
            end
            S_PROBE: state_next = (lo_reg < hi_reg) ? S_CMP : S_EMIT;
            S_CMP:   state_next = hit ? S_EMIT : S_PROBE;
            S_EMIT:  if (out_free && eend) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_code_reg  <= '0;
            lead_reg       <= '0;
            lead_valid_reg <= 1'b0;
            prev_pin_reg   <= 1'b0;
            emitted_reg    <= 1'b0;
            last_sp_reg    <= 1'b0;
            ovalid_reg     <= 1'b0;
            step_reg       <= E_DONE;
        end else begin
            state_reg <= state_next;

            // table append
            if (wr_en) begin
                count_reg <= count_reg + 1'b1;
                last_code_reg <= s_axis_tdata[23:8];
            end

            // output register
            if (out_load) begin
                ovalid_reg <= 1'b1;
                obuf_reg <= out_word;
                olast_reg <= out_last;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end

            // text flags
            if (end_acc) begin
                emitted_reg <= 1'b0;
                last_sp_reg <= 1'b0;
            end else if (out_char) begin
                emitted_reg <= 1'b1;
                last_sp_reg <= is_space(ech);
            end
            if (end_acc) begin
                prev_pin_reg <= 1'b0;
            end else if (state_reg == S_CMP && hit) begin
                prev_pin_reg <= 1'b1;
            end else if (state_reg == S_EMIT && out_free && step_reg == E_PB1) begin
                prev_pin_reg <= 1'b0;
            end

            // held lead byte
            if (end_acc) begin
                lead_valid_reg <= 1'b0;
                lead_reg <= '0;
            end else if (text_acc) begin
                lead_valid_reg <= !pair_now && is_lead(in_byte);
                if (!pair_now && is_lead(in_byte)) lead_reg <= in_byte;
            end

            // sequence setup, search and emit progress
            if (text_acc) begin
                pa_reg <= lead_valid_reg ? lead_reg : in_byte;
                b_reg <= in_byte;
                plain2_reg <= pair_now || (lead_valid_reg && !is_lead(in_byte));
                lo_reg <= '0;
                hi_reg <= count_reg;
                step_reg <= E_PPAD;
            end else if (state_reg == S_CMP) begin
                if (hit) begin
                    let_reg <= rd_letters; nlet_reg <= nl_calc;
                    li_reg <= '0; step_reg <= E_PAD;
                end else if (rd_code < key) begin
                    lo_reg <= mid + 1'b1;
                end else begin
                    hi_reg <= mid;
                end
            end else if (state_reg == S_EMIT && out_free) begin
                step_reg <= estep_n;
                if (step_reg == E_LET) begin
                    li_reg <= li_reg + 1'b1;
                    let_reg <= let_reg >> 8;
                end
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obuf_reg;
    assign m_axis_tlast  = olast_reg;

    `include "gbk_to_pinyin_stream_unit_assert.svh"

    // no new item while the sequencer is busy searching or emitting
    `G2P_ASSERT(a_busy, aclk, aresetn, (state_reg != S_IDLE) |-> !s_axis_tready, "busy accept")
    // a stalled result word holds its value
    `G2P_ASSERT_NEXT(a_hold, aclk, aresetn, ovalid_reg && !m_axis_tready, $stable(obuf_reg), "stall")
    // search bounds stay ordered
    `G2P_ASSERT(a_bounds, aclk, aresetn, (state_reg == S_CMP) |-> (lo_reg < hi_reg), "bounds")
endmodule
`default_nettype wire

/* sim/tb_gbk_to_pinyin_stream_unit.sv */
// testbench for the gbk to pinyin stream unit: table loads, text streams, option sweeps
`timescale 1ns / 100ps
`default_nettype none
module tb_gbk_to_pinyin_stream_unit;
    import g2p_pkg::*;

    localparam int unsigned DEPTH = 32768;

    // one input word as the driver presents it
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  in_byte;
        logic [15:0] entry_code;
        logic [47:0] entry_letters;
        logic [2:0]  entry_len;
    } g2p_item_t;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } g2p_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    gbk_to_pinyin_stream_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // predictor state
    logic [15:0] tbl_code [DEPTH];
    logic [47:0] tbl_letters [DEPTH];
    logic [2:0]  tbl_len [DEPTH];
    int unsigned tbl_count = 0;
    logic [15:0] last_code = '0;
    logic [7:0]  held_lead = '0;
    logic        held_valid = 1'b0;
    logic        after_pinyin = 1'b0;
    logic        any_out = 1'b0;
    logic        out_was_space = 1'b0;
    cfg_t        opts;

    g2p_item_t   pending_items[$];
    g2p_word_t   expected_words[$];
    int          error_count = 0;
    int          words_seen = 0;
    int          hits_seen = 0;
    bit          in_taken;

    task automatic report(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // character helpers kept local to the predictor
    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit lead_byte(input logic [7:0] h);
        return h >= 8'h81 && h <= 8'hFE;
    endfunction

    function automatic bit rng(input logic [7:0] v, input logic [7:0] lo, input logic [7:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic bit gbk_pair(input logic [7:0] h, input logic [7:0] l);
        bit la, lb;
        la = rng(l, 8'hA1, 8'hFE);
        lb = rng(l, 8'h40, 8'hA0) && l != 8'h7F;
        if (!lead_byte(h)) return 0;
        return (rng(h, 8'hA1, 8'hA9) && la) || (rng(h, 8'hB0, 8'hF7) && la)
            || (rng(h, 8'h81, 8'hA0) && rng(l, 8'h40, 8'hFE) && l != 8'h7F)
            || (rng(h, 8'hAA, 8'hFE) && lb) || (rng(h, 8'hA8, 8'hA9) && lb)
            || (rng(h, 8'hAA, 8'hAF) && la) || (rng(h, 8'hF8, 8'hFE) && la)
            || (rng(h, 8'hA1, 8'hA7) && lb);
    endfunction

    function automatic int find_code(input logic [15:0] code);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_code[mid] == code) return int'(mid);
            if (tbl_code[mid] < code) lo = mid + 1;
            else hi = mid;
        end
        return -1;
    endfunction

    task automatic push_word(input logic [7:0] b, input bit v, input logic [1:0] st);
        g2p_word_t w;
        w.out_byte = v ? b : 8'h00;
        w.byte_valid = v;
        w.status = st;
        w.last = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic put_char(input logic [7:0] c);
        push_word(c, 1, ST_OK);
        any_out = 1;
        out_was_space = blank(c);
    endtask

    task automatic put_plain(input logic [7:0] a, input logic [7:0] b, input bit two);
        if (opts.auto_pad && after_pinyin && !blank(a)) put_char(CH_SPACE);
        put_char(a);
        if (two) put_char(b);
        after_pinyin = 0;
    endtask

    task automatic put_pinyin(input logic [7:0] h, input logic [7:0] l, input int idx);
        int n;
        logic [7:0] c;
        n = opts.initials_only ? 1 : tbl_len[idx];
        if (n < 1) n = 1;
        if (n > 6) n = 6;
        if (opts.auto_pad && any_out && !out_was_space) put_char(CH_SPACE);
        if (opts.with_original) begin
            put_char(h);
            put_char(l);
            put_char(CH_OPEN);
        end
        for (int i = 0; i < n; i++) begin
            c = tbl_letters[idx][8*i +: 8];
            if ((i == 0 ? opts.upper_first : opts.upper_rest) && c >= 8'h61 && c <= 8'h7A)
                c = c - 8'd32;
            put_char(c);
        end
        if (opts.with_original) put_char(CH_CLOSE);
        after_pinyin = 1;
    endtask

    // expected words for one accepted item
    task automatic predict_item(input g2p_item_t it);
        int before_n, idx;
        logic [7:0] h;
        g2p_word_t w;
        before_n = expected_words.size();
        case (it.mode)
            MODE_TEXT: begin
                if (held_valid) begin
                    h = held_lead;
                    held_valid = 0;
                    held_lead = 0;
                    if (gbk_pair(h, it.in_byte)) begin
                        idx = find_code({h, it.in_byte});
                        if (idx >= 0) put_pinyin(h, it.in_byte, idx);
                        else put_plain(h, it.in_byte, 1);
                        it.mode = 2'd3;
                    end else begin
                        put_plain(h, 8'h00, 0);
                    end
                end
                if (it.mode == MODE_TEXT) begin
                    if (lead_byte(it.in_byte)) begin
                        held_lead = it.in_byte;
                        held_valid = 1;
                    end else begin
                        put_plain(it.in_byte, 8'h00, 0);
                    end
                end
            end
            MODE_LOAD: begin
                if (tbl_count >= DEPTH) push_word(0, 0, ST_FULL);
                else if (it.entry_code <= last_code) push_word(0, 0, ST_ORDER);
                else begin
                    tbl_code[tbl_count] = it.entry_code;
                    tbl_letters[tbl_count] = it.entry_letters;
                    tbl_len[tbl_count] = it.entry_len;
                    tbl_count++;
                    last_code = it.entry_code;
                    push_word(0, 0, ST_OK);
                end
            end
            MODE_END: begin
                if (held_valid) push_word(0, 0, ST_DROP);
                held_valid = 0;
                held_lead = 0;
                after_pinyin = 0;
                any_out = 0;
                out_was_space = 0;
            end
            default: ;
        endcase
        if (expected_words.size() > before_n) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
    end

    // input driver: random gaps, changes on the falling edge
    int drv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            drv_gap = 0;
        end else begin
            if (in_taken) begin
                predict_item(pending_items.pop_front());
                drv_gap = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
            end
            if (s_axis_tvalid && !in_taken) begin
                // hold the word until taken
            end else if (drv_gap > 0 || pending_items.size() == 0) begin
                if (drv_gap > 0) drv_gap--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_items[0].mode;
                s_axis_tdata <= {5'd0, pending_items[0].entry_len, pending_items[0].entry_letters,
                                 pending_items[0].entry_code, pending_items[0].in_byte};
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        g2p_word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
            end else begin
                w = expected_words.pop_front();
                if (m_axis_tdata[7:0] != w.out_byte)
                    report($sformatf("out_byte %h, wanted %h", m_axis_tdata[7:0], w.out_byte));
                if (m_axis_tdata[8] != w.byte_valid)
                    report($sformatf("byte_valid %b, wanted %b", m_axis_tdata[8], w.byte_valid));
                if (m_axis_tdata[10:9] != w.status)
                    report($sformatf("status %0d, wanted %0d", m_axis_tdata[10:9], w.status));
                if (m_axis_tlast != w.last)
                    report($sformatf("last %b, wanted %b", m_axis_tlast, w.last));
                if (w.byte_valid && w.out_byte == CH_OPEN) hits_seen++;
            end
        end
    end

    // receiver stalls
    int rcv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rcv_gap = 0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rcv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic g2p_item_t text_item(input logic [7:0] b);
        g2p_item_t it;
        it = '0;
        it.mode = MODE_TEXT;
        it.in_byte = b;
        it.entry_code = 16'($urandom);
        it.entry_letters = {16'($urandom), 32'($urandom)};
        it.entry_len = 3'($urandom);
        return it;
    endfunction

    function automatic g2p_item_t load_item(input logic [15:0] code, input logic [47:0] letters,
                                            input logic [2:0] len);
        g2p_item_t it;
        it = text_item(8'($urandom));
        it.mode = MODE_LOAD;
        it.entry_code = code;
        it.entry_letters = letters;
        it.entry_len = len;
        return it;
    endfunction

    function automatic g2p_item_t ctl_item(input logic [1:0] m);
        g2p_item_t it;
        it = text_item(8'($urandom));
        it.mode = m;
        return it;
    endfunction

    function automatic logic [47:0] rand_letters();
        logic [47:0] l;
        for (int i = 0; i < 6; i++)
            l[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7A));
        return l;
    endfunction

    // wait until every queued item is taken and every word has come back
    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {7'($urandom) & 7'h7F, v};
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_INITIALS: opts.initials_only = v;
            CFG_PAD:      opts.auto_pad = v;
            CFG_ORIG:     opts.with_original = v;
            CFG_UPFIRST:  opts.upper_first = v;
            default:      opts.upper_rest = v;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_opts(input logic [4:0] v);
        write_cfg(CFG_INITIALS, v[4]);
        write_cfg(CFG_PAD, v[3]);
        write_cfg(CFG_ORIG, v[2]);
        write_cfg(CFG_UPFIRST, v[1]);
        write_cfg(CFG_UPREST, v[0]);
    endtask

    // random text: mostly known pairs, some random pairs, noise and ends
    task automatic random_text(input int n);
        int k, sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5 && tbl_count > 0) begin
                k = $urandom_range(0, tbl_count - 1);
                pending_items.push_back(text_item(tbl_code[k][15:8]));
                pending_items.push_back(text_item(tbl_code[k][7:0]));
            end else if (sel < 7) begin
                pending_items.push_back(text_item(8'($urandom_range(8'h81, 8'hFE))));
                pending_items.push_back(text_item(8'($urandom)));
            end else if (sel < 9) begin
                pending_items.push_back(text_item(($urandom_range(0, 2) == 0) ?
                    8'($urandom_range(8'h09, 8'h0D)) | 8'h00 : 8'($urandom)));
            end else begin
                pending_items.push_back(ctl_item(($urandom_range(0, 3) == 0) ? 2'd3 : MODE_END));
            end
        end
    endtask

    initial begin
        logic [15:0] code;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        opts = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: a pair before any table exists, code zero, ordered and out-of-order loads
        pending_items.push_back(text_item(8'hB0));
        pending_items.push_back(text_item(8'hA1));
        pending_items.push_back(load_item(16'h0000, '1, 3'd7));
        pending_items.push_back(load_item(16'h8140, 48'h6E_61_6E_67_68_7A, 3'd6));
        pending_items.push_back(load_item(16'hB0A1, 48'h0000_0000_6961, 3'd0));
        pending_items.push_back(load_item(16'hB0A1, 48'h0, 3'd2));
        pending_items.push_back(load_item(16'hD6D0, 48'h00_67_6E_6F_68_7A, 3'd5));
        pending_items.push_back(load_item(16'hFEFE, 48'hFF_7A_41_5B_61_60, 3'd7));
        pending_items.push_back(load_item(16'h1234, 48'h0, 3'd1));
        // hits, invalid pairs, spaces and a dangling lead
        pending_items.push_back(text_item(8'h41));
        pending_items.push_back(text_item(8'hD6));
        pending_items.push_back(text_item(8'hD0));
        pending_items.push_back(text_item(8'h81));
        pending_items.push_back(text_item(8'h40));
        pending_items.push_back(text_item(8'h20));
        pending_items.push_back(text_item(8'hFE));
        pending_items.push_back(text_item(8'hFE));
        pending_items.push_back(text_item(8'h81));
        pending_items.push_back(text_item(8'h7F));
        pending_items.push_back(text_item(8'hFF));
        pending_items.push_back(text_item(8'hB0));
        pending_items.push_back(ctl_item(MODE_END));
        pending_items.push_back(ctl_item(MODE_END));
        pending_items.push_back(ctl_item(2'd3));
        drain();

        // try to grow the table with random codes, none above the last loaded code
        code = 16'hFEFE;
        for (int i = 0; i < 20; i++) begin
            code = 16'($urandom_range(16'h8140, 16'hFEFE));
            pending_items.push_back(load_item(code, rand_letters(), 3'($urandom)));
        end
        drain();
        // the table already ends at code FEFE, so every such load is refused as out of order

        // text phases across option settings, all options on first and all off last
        set_opts(5'b11111);
        random_text(15);
        drain();
        set_opts(5'b01110);
        random_text(15);
        drain();
        set_opts(5'b10001);
        random_text(15);
        drain();
        set_opts(5'($urandom_range(0, 31)));
        random_text(15);
        drain();
        set_opts(5'b00000);
        random_text(15);
        drain();

        $display("covered %0d result words over five option settings, %0d table entries",
                 words_seen, tbl_count);
        $display("bracketed pinyin results seen: %0d", hits_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/g2p_pkg.sv
sv/g2p_table.sv
sv/gbk_to_pinyin_stream_unit.sv
sim/tb_gbk_to_pinyin_stream_unit.sv
